// ===== sv/sfg_pkg.sv =====
// shared constants and types for the synthetic field generator
// no dependencies
`default_nettype none
package sfg_pkg;
    localparam int unsigned MaxTextLength = 62;
    localparam int unsigned MaxColumns = 256;
    localparam logic [31:0] ColMult = 32'h0000_9E37;
    localparam logic [1:0] TypeInt = 2'd0;
    localparam logic [1:0] TypeBool = 2'd1;
    localparam logic [1:0] TypeStr = 2'd2;
    localparam logic [1:0] TypeNa = 2'd3;
    localparam logic [1:0] RegSeed = 2'd0;
    localparam logic [1:0] RegMaxNum = 2'd1;
    localparam logic [1:0] RegIdWidth = 2'd2;
    localparam logic [1:0] RegStrLen = 2'd3;

    typedef struct packed {
        logic       start;
        logic [6:0] width;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    function automatic logic [7:0] letter52(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'(8'd65 + 8'(v));
        end else begin
            r = 8'(8'd71 + 8'(v));
        end
        return r;
    endfunction

    function automatic logic [31:0] xs_step(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction
endpackage
`default_nettype wire

// ===== sv/sfg_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on sfg_pkg
`default_nettype none
module sfg_div (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire sfg_pkg::div_req_t req,
    output logic                  done,
    output logic [63:0]           quo,
    output logic [63:0]           rem
);
    logic [63:0] quo_reg, quo_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[63:0], quo_reg[63]};
        if (req.start) begin
            quo_next = req.num << (7'd64 - req.width);
            rem_next = '0;
            den_next = req.den;
            cnt_next = req.width;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo = quo_reg;
    assign rem = rem_reg[63:0];
endmodule
`default_nettype wire

// ===== sv/synthetic_field_generator.sv =====
// cell text generator: identifier digits, xorshift32 random values, ascii output
// depends on sfg_pkg and sfg_div
// one cell at a time: an identifier cell with a nonzero base takes two 64-bit divisions,
// a random integer a 32-bit modulo, each decimal or base-26 digit a 64-bit division and
// each random letter a 32-bit modulo; all run on the bit-serial divider
// reset clears config to seed 0, max_num 0, str_id_width 1, rand_str_len 12
`default_nettype none
module synthetic_field_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // row_index, column_index, column_type, id_cell, id_factor, id_base, is_last_column
    input  wire logic [207:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // text_char
    output logic [7:0]       m_tdata,
    // is_last
    output logic             m_tlast
);
    localparam logic [3:0] StIdle = 4'd0, StDiv1 = 4'd1, StDiv2 = 4'd2,
        StRand = 4'd3, StMod = 4'd4, StDec = 4'd5, StB26 = 4'd6, StEmit = 4'd7,
        StStr = 4'd8, StStrMod = 4'd9, StSep = 4'd10, StWait = 4'd11,
        StStack = 4'd12, StStrOut = 4'd13;

    logic [31:0] seed_reg, max_reg;
    logic [3:0]  idw_reg;
    logic [5:0]  len_reg;
    logic [3:0]  st_reg, st_next;
    logic [63:0] val_reg, val_next;
    logic [63:0] base_reg, base_next;
    logic [31:0] xs_reg, xs_next;
    logic [1:0]  typ_reg, typ_next;
    logic        lastc_reg, lastc_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [7:0]  stk_reg [0:19];
    logic [4:0]  sp_reg, sp_next;
    logic        push;
    logic [7:0]  push_ch;
    logic [7:0]  out_reg, out_next;
    logic        ov_reg, ov_next, ol_reg, ol_next;
    sfg_pkg::div_req_t dreq;
    logic        ddone;
    logic [63:0] dquo, drem;
    logic [63:0] row;
    logic [7:0]  col;
    logic [1:0]  ctype;
    logic        ident;
    logic [63:0] fac, bas;
    logic [3:0]  idw;
    logic [5:0]  slen;
    logic        out_free;

    assign row = s_tdata[63:0];
    assign col = s_tdata[71:64];
    assign ctype = s_tdata[73:72];
    assign ident = s_tdata[74];
    assign fac = s_tdata[138:75];
    assign bas = s_tdata[202:139];
    assign idw = (idw_reg == 4'd0) ? 4'd1 : ((idw_reg > 4'd13) ? 4'd13 : idw_reg);
    assign slen = (len_reg == 6'd0) ? 6'd12 :
        ((len_reg > 6'(sfg_pkg::MaxTextLength)) ? 6'(sfg_pkg::MaxTextLength) : len_reg);
    assign out_free = !ov_reg || m_tready;

    sfg_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(ddone),
        .quo(dquo), .rem(drem));

    always_comb begin
        st_next = st_reg;
        val_next = val_reg;
        base_next = base_reg;
        xs_next = xs_reg;
        typ_next = typ_reg;
        lastc_next = lastc_reg;
        cnt_next = cnt_reg;
        sp_next = sp_reg;
        push = 1'b0;
        push_ch = '0;
        out_next = out_reg;
        ov_next = ov_reg && !m_tready;
        ol_next = ol_reg;
        dreq = '0;
        s_tready = (st_reg == StIdle);
        case (st_reg)
            StIdle: begin
                if (s_tvalid) begin
                    typ_next = ctype;
                    lastc_next = s_tdata[203];
                    val_next = row;
                    base_next = bas;
                    cnt_next = 6'(idw);
                    xs_next = seed_reg ^ row[31:0] ^ 32'(32'(col) * sfg_pkg::ColMult);
                    if (ident) begin
                        if (ctype == sfg_pkg::TypeInt || ctype == sfg_pkg::TypeStr) begin
                            if (bas != 64'd0) begin
                                dreq.start = 1'b1;
                                dreq.width = 7'd64;
                                dreq.num = row;
                                dreq.den = (fac == 64'd0) ? 64'd1 : fac;
                                st_next = StDiv1;
                            end else begin
                                st_next = (ctype == sfg_pkg::TypeInt) ? StDec : StB26;
                            end
                        end else begin
                            st_next = StSep;
                        end
                    end else begin
                        st_next = StRand;
                    end
                end
            end
            StDiv1: begin
                if (ddone) begin
                    dreq.start = 1'b1;
                    dreq.width = 7'd64;
                    dreq.num = dquo;
                    dreq.den = base_reg;
                    st_next = StDiv2;
                end
            end
            StDiv2: begin
                if (ddone) begin
                    val_next = drem;
                    st_next = (typ_reg == sfg_pkg::TypeInt) ? StDec : StB26;
                end
            end
            StRand: begin
                case (typ_reg)
                    sfg_pkg::TypeInt: begin
                        xs_next = sfg_pkg::xs_step(xs_reg);
                        if (max_reg == 32'd0) begin
                            val_next = '0;
                            st_next = StDec;
                        end else begin
                            dreq.start = 1'b1;
                            dreq.width = 7'd32;
                            dreq.num = {32'd0, sfg_pkg::xs_step(xs_reg)};
                            dreq.den = {32'd0, max_reg};
                            st_next = StMod;
                        end
                    end
                    sfg_pkg::TypeBool: begin
                        if (sfg_pkg::xs_step(xs_reg)[0]) begin
                            val_next = {32'd0, "True"};
                            cnt_next = 6'd4;
                        end else begin
                            val_next = {24'd0, "False"};
                            cnt_next = 6'd5;
                        end
                        st_next = StEmit;
                    end
                    sfg_pkg::TypeStr: begin
                        cnt_next = slen;
                        st_next = StStr;
                    end
                    default: begin
                        val_next = {48'd0, "NA"};
                        cnt_next = 6'd2;
                        st_next = StEmit;
                    end
                endcase
            end
            StMod: begin
                if (ddone) begin
                    val_next = drem;
                    st_next = StDec;
                end
            end
            StDec: begin
                dreq.start = 1'b1;
                dreq.width = 7'd64;
                dreq.num = val_reg;
                dreq.den = 64'd10;
                st_next = StWait;
            end
            StB26: begin
                dreq.start = 1'b1;
                dreq.width = 7'd64;
                dreq.num = val_reg;
                dreq.den = 64'd26;
                st_next = StWait;
            end
            StWait: begin
                if (ddone) begin
                    push = 1'b1;
                    sp_next = sp_reg + 5'd1;
                    val_next = dquo;
                    if (typ_reg == sfg_pkg::TypeInt) begin
                        push_ch = 8'(8'd48 + drem[7:0]);
                        st_next = (dquo == 64'd0) ? StStack : StDec;
                    end else begin
                        push_ch = 8'(8'd65 + drem[7:0]);
                        cnt_next = cnt_reg - 6'd1;
                        st_next = (cnt_reg == 6'd1) ? StStack : StB26;
                    end
                end
            end
            StStack: begin
                if (out_free) begin
                    if (sp_reg == 5'd0) begin
                        st_next = StSep;
                    end else begin
                        out_next = stk_reg[sp_reg - 5'd1];
                        ov_next = 1'b1;
                        ol_next = 1'b0;
                        sp_next = sp_reg - 5'd1;
                    end
                end
            end
            StEmit: begin
                if (out_free) begin
                    out_next = val_reg[8*cnt_reg-1 -: 8];
                    ov_next = 1'b1;
                    ol_next = 1'b0;
                    cnt_next = cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        st_next = StSep;
                    end
                end
            end
            StStr: begin
                xs_next = sfg_pkg::xs_step(xs_reg);
                dreq.start = 1'b1;
                dreq.width = 7'd32;
                dreq.num = {32'd0, sfg_pkg::xs_step(xs_reg)};
                dreq.den = 64'd52;
                st_next = StStrMod;
            end
            StStrMod: begin
                if (ddone) begin
                    val_next = drem;
                    st_next = StStrOut;
                end
            end
            StStrOut: begin
                if (out_free) begin
                    out_next = sfg_pkg::letter52(val_reg[5:0]);
                    ov_next = 1'b1;
                    ol_next = 1'b0;
                    cnt_next = cnt_reg - 6'd1;
                    st_next = (cnt_reg == 6'd1) ? StSep : StStr;
                end
            end
            StSep: begin
                if (out_free) begin
                    out_next = lastc_reg ? 8'h0A : 8'h2C;
                    ov_next = 1'b1;
                    ol_next = 1'b1;
                    st_next = StIdle;
                end
            end
            default: st_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
            max_reg <= '0;
            idw_reg <= 4'd1;
            len_reg <= 6'd12;
            st_reg <= StIdle;
            sp_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    sfg_pkg::RegSeed: seed_reg <= cfg_data;
                    sfg_pkg::RegMaxNum: max_reg <= cfg_data;
                    sfg_pkg::RegIdWidth: idw_reg <= cfg_data[3:0];
                    sfg_pkg::RegStrLen: len_reg <= cfg_data[5:0];
                    default: ;
                endcase
            end
            st_reg <= st_next;
            sp_reg <= sp_next;
            ov_reg <= ov_next;
        end
        if (push) begin
            stk_reg[sp_reg] <= push_ch;
        end
        val_reg <= val_next;
        base_reg <= base_next;
        xs_reg <= xs_next;
        typ_reg <= typ_next;
        lastc_reg <= lastc_next;
        cnt_reg <= cnt_next;
        out_reg <= out_next;
        ol_reg <= ol_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata = out_reg;
    assign m_tlast = ol_reg;
endmodule
`default_nettype wire

// ===== sv/sfg_checker.sv =====
// port-level checks for the synthetic field generator
// depends on synthetic_field_generator ports
`default_nettype none
module sfg_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled word changed");
    a_sep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == 8'h2C || m_tdata == 8'h0A)
        else $error("bad separator");
    a_body: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata != 8'h2C && m_tdata != 8'h0A)
        else $error("separator in text");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted while busy");
endmodule
bind synthetic_field_generator sfg_checker u_chk (.*);
`default_nettype wire
